// ===== hdl/stable_matching_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stable matching engine.
// Both macros assume signals named clk and arst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef STABLE_MATCHING_ENGINE_DEFINES_SVH
`define STABLE_MATCHING_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SME_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// sme_pkg
// Shared constants and types of the stable matching engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sme_pkg;

	// Table geometry: one row of MAX_PEOPLE entries per person.
	localparam int MAX_PEOPLE  = 16;
	localparam int IDX_W       = $clog2(MAX_PEOPLE);
	localparam int TABLE_DEPTH = MAX_PEOPLE * MAX_PEOPLE;
	localparam int COUNT_W     = 9;
	localparam int NUM_W       = 5;

	// Stream payload widths.
	localparam int S_DATA_W = 16;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 24;

	// APB port geometry.
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [1:0]       func_t;

	// Request function codes.
	localparam func_t FUNC_LOAD_PREF = 2'd0;
	localparam func_t FUNC_LOAD_RANK = 2'd1;
	localparam func_t FUNC_RUN       = 2'd2;

	// Register index of num_people (word index taken from paddr[2]).
	localparam logic REG_NUM_PEOPLE = 1'b0;

	// Partner slot: bit 4 set means free.
	localparam logic [4:0] PARTNER_FREE = 5'h1F;

endpackage

// ===== hdl/sme_ram.sv =====
// ----------------------------------------------------------------------------
// sme_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sme_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/stable_matching_engine.sv =====
// ----------------------------------------------------------------------------
// stable_matching_engine
// Proposer-optimal Gale-Shapley matching over loaded preference and rank
// tables held in two block RAMs.
// ----------------------------------------------------------------------------
// Channel   Ports                 Direction  Moves
// cfg       psel..prdata, pready  in/out     num_people register (APB)
// s         s_tvalid/tready/...   in         table load or run request
// m         m_tvalid/tready/...   out        one result per proposer
//
// Loads write straight into the RAMs. A proposal to a free acceptor passes
// ST_PREF, a contested one also ST_RNEW and ST_RCUR (the rank RAM has one
// read port, so both ranks are read in turn); results follow one per cycle
// while m_tready is high. Reset clears the run state; the tables are not
// cleared and need no clearing pass. A stalled result holds in the output
// register; loads are taken again once a run's last result is in that register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_matching_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sme_pkg::CFG_AW-1:0]    paddr,
	input  logic [sme_pkg::CFG_DW-1:0]    pwdata,
	output logic [sme_pkg::CFG_DW-1:0]    prdata,
	output logic                          pready,
	// Request stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata from bit 0: person[3:0], slot[7:4], entry_value[11:8], zero fill.
	input  logic [sme_pkg::S_DATA_W-1:0]  s_tdata,
	// s_tuser from bit 0: func[1:0].
	input  logic [sme_pkg::S_USER_W-1:0]  s_tuser,
	// Result stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata from bit 0: proposer[3:0], partner[7:4], proposal_count[16:8],
	// zero fill.
	output logic [sme_pkg::M_DATA_W-1:0]  m_tdata,
	// m_tuser from bit 0: status[0].
	output logic [0:0]                    m_tuser,
	output logic                          m_tlast
);

	import sme_pkg::*;

	localparam int TAW = $clog2(TABLE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_PREF,
		ST_RNEW,
		ST_RCUR,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [NUM_W-1:0]     num_people_q;
	logic [NUM_W-1:0]     n_q;
	idx_t                 p_q;
	idx_t                 a_q;
	idx_t                 cur_q;
	logic [3:0]           rnew_q;
	logic                 pass_free_q;
	logic                 ok_q;
	logic [COUNT_W-1:0]   proposals_q;
	logic [4:0]           pp_q [MAX_PEOPLE];
	logic [4:0]           ap_q [MAX_PEOPLE];
	logic [NUM_W-1:0]     nc_q [MAX_PEOPLE];
	logic                 m_valid_q;
	logic [M_DATA_W-1:0]  m_data_q;
	logic                 m_status_q;
	logic                 m_last_q;

	logic                 cfg_wr;
	logic                 in_acc;
	func_t                in_func;
	idx_t                 in_person;
	idx_t                 in_slot;
	logic [3:0]           in_value;
	logic [NUM_W-1:0]     n_clamped;
	idx_t                 n_last;
	logic                 out_load;
	logic                 pref_we;
	logic                 rank_we;
	logic [TAW-1:0]       load_addr;
	logic [TAW-1:0]       pref_raddr;
	logic [TAW-1:0]       rank_raddr;
	logic [3:0]           pref_rdata;
	logic [3:0]           rank_rdata;

	// Configuration register write and readback.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_NUM_PEOPLE);

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_NUM_PEOPLE) begin
			prdata = {{(CFG_DW-NUM_W){1'b0}}, num_people_q};
		end
	end

	// Request fields.
	assign in_func   = s_tuser;
	assign in_person = s_tdata[3:0];
	assign in_slot   = s_tdata[7:4];
	assign in_value  = s_tdata[11:8];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;

	// Number of people clamped to the supported range.
	always_comb begin
		n_clamped = num_people_q;
		if (num_people_q < 5'd2) begin
			n_clamped = 5'd2;
		end else if (num_people_q > NUM_W'(MAX_PEOPLE)) begin
			n_clamped = NUM_W'(MAX_PEOPLE);
		end
	end

	assign n_last = IDX_W'(n_q - 5'd1);

	// Table loads write straight into the RAMs.
	assign load_addr = {in_person, in_slot};
	assign pref_we   = in_acc && (in_func == FUNC_LOAD_PREF);
	assign rank_we   = in_acc && (in_func == FUNC_LOAD_RANK);

	// Read addresses: next list entry of the current proposer; the rank RAM
	// reads the newcomer's rank first and the current partner's rank second.
	assign pref_raddr = {p_q, nc_q[p_q][IDX_W-1:0]};

	always_comb begin
		if (state_q == ST_PREF) begin
			rank_raddr = {pref_rdata, p_q};
		end else begin
			rank_raddr = {a_q, cur_q};
		end
	end

	sme_ram #(.WIDTH(4), .DEPTH(TABLE_DEPTH)) u_pref_ram (
		.clk   (clk),
		.we    (pref_we),
		.waddr (load_addr),
		.wdata (in_value),
		.raddr (pref_raddr),
		.rdata (pref_rdata)
	);

	sme_ram #(.WIDTH(4), .DEPTH(TABLE_DEPTH)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (load_addr),
		.wdata (in_value),
		.raddr (rank_raddr),
		.rdata (rank_rdata)
	);

	// The output register takes a new result when it is empty or being drained.
	assign out_load = (state_q == ST_EMIT) && (!m_valid_q || m_tready);

	// Sequencer, run state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			num_people_q <= NUM_W'(MAX_PEOPLE);
			n_q          <= NUM_W'(MAX_PEOPLE);
			p_q          <= '0;
			a_q          <= '0;
			cur_q        <= '0;
			rnew_q       <= '0;
			pass_free_q  <= 1'b0;
			ok_q         <= 1'b1;
			proposals_q  <= '0;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
			m_status_q   <= 1'b0;
			m_last_q     <= 1'b0;
			for (int i = 0; i < MAX_PEOPLE; i++) begin
				pp_q[i] <= PARTNER_FREE;
				ap_q[i] <= PARTNER_FREE;
				nc_q[i] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				num_people_q <= pwdata[NUM_W-1:0];
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					// A run request clears the run state and starts the sweep.
					if (in_acc && (in_func == FUNC_RUN)) begin
						n_q         <= n_clamped;
						p_q         <= '0;
						pass_free_q <= 1'b0;
						ok_q        <= 1'b1;
						proposals_q <= '0;
						for (int i = 0; i < MAX_PEOPLE; i++) begin
							pp_q[i] <= PARTNER_FREE;
							ap_q[i] <= PARTNER_FREE;
							nc_q[i] <= '0;
						end
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (pp_q[p_q][4]) begin
						// Free proposer: propose next, or stop on an empty list.
						pass_free_q <= 1'b1;
						if (nc_q[p_q] >= n_q) begin
							ok_q    <= 1'b0;
							p_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_PREF;
						end
					end else if (p_q == n_last) begin
						// End of a pass: repeat while anybody was free.
						p_q <= '0;
						if (pass_free_q) begin
							pass_free_q <= 1'b0;
						end else begin
							state_q <= ST_EMIT;
						end
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				ST_PREF: begin
					// The list entry is in; a free acceptor takes him at once.
					nc_q[p_q]   <= nc_q[p_q] + 1'b1;
					proposals_q <= proposals_q + 1'b1;
					a_q         <= pref_rdata;
					cur_q       <= ap_q[pref_rdata][IDX_W-1:0];
					if (ap_q[pref_rdata][4]) begin
						pp_q[p_q]        <= {1'b0, pref_rdata};
						ap_q[pref_rdata] <= {1'b0, p_q};
						state_q          <= ST_SWEEP;
					end else begin
						state_q <= ST_RNEW;
					end
				end
				ST_RNEW: begin
					rnew_q  <= rank_rdata;
					state_q <= ST_RCUR;
				end
				ST_RCUR: begin
					// Ties go to the newcomer; the displaced partner becomes free.
					if (rnew_q <= rank_rdata) begin
						pp_q[cur_q] <= PARTNER_FREE;
						ap_q[a_q]   <= {1'b0, p_q};
						pp_q[p_q]   <= {1'b0, a_q};
					end
					state_q <= ST_SWEEP;
				end
				ST_EMIT: begin
					if (out_load) begin
						m_data_q   <= {{(M_DATA_W-8-COUNT_W){1'b0}}, proposals_q,
							(pp_q[p_q][4] ? 4'd0 : pp_q[p_q][3:0]), p_q};
						m_status_q <= !ok_q;
						m_last_q   <= (p_q == n_last);
						if (p_q == n_last) begin
							p_q     <= '0;
							state_q <= ST_IDLE;
						end else begin
							p_q <= p_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_status_q;
	assign m_tlast    = m_last_q;

endmodule

// ===== hdl/sme_checker.sv =====
// ----------------------------------------------------------------------------
// sme_checker
// Port-level checks of the stable matching engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stable_matching_engine_defines.svh"

module sme_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [sme_pkg::S_USER_W-1:0]  s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [sme_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic [0:0]                    m_tuser,
	input  logic                          m_tlast
);

	import sme_pkg::*;

	// A stalled result keeps its contents.
	`SME_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
		"result changed while stalled")

	// No request is taken while a run still has results to hand out.
	`SME_ASSERT_NOW(a_busy_in_results, m_tvalid && !m_tlast, !s_tready,
		"request accepted in the middle of a run's results")

	// Results of a run follow back to back with the next proposer index and
	// the same count and status.
	`SME_ASSERT_NEXT(a_result_order, m_tvalid && m_tready && !m_tlast,
		m_tvalid && (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1)
			&& $stable(m_tdata[16:8]) && $stable(m_tuser),
		"results of a run out of order")

	// A table load leaves the engine ready for the next request.
	`SME_ASSERT_NEXT(a_load_ready, s_tvalid && s_tready && (s_tuser != FUNC_RUN),
		s_tready, "engine busy after a table load")

endmodule

bind stable_matching_engine sme_checker u_sme_checker (.*);
